// File: rtl/per_cpu_work_stealing_queues_core_defines.svh
// assertion macros for the checker file of the work stealing queue block
`ifndef PER_CPU_WORK_STEALING_QUEUES_CORE_DEFINES_SVH
`define PER_CPU_WORK_STEALING_QUEUES_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PCWS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PCWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pcws_pkg.sv
// shared constants, codes and types of the work stealing queue block
package pcws_pkg;

    // queue set geometry
    localparam int CPU_BITS             = 3;
    localparam int CPU_COUNT            = 1 << CPU_BITS;
    localparam int DEF_SLOTS_PER_QUEUE  = 64;
    localparam int DEF_HANDLE_BITS      = 32;

    // request kinds
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // result status codes
    localparam int          STATUS_BITS    = 2;
    localparam logic [1:0]  STAT_DONE      = 2'd0;
    localparam logic [1:0]  STAT_FULL      = 2'd1;
    localparam logic [1:0]  STAT_NO_WORK   = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic exec;   // request transfer: decide, update counters, access slots
        logic load;   // move the finished result into the output register
    } pcws_cmd_t;

endpackage

// File: rtl/pcws_ctrl.sv
// controller: sequences one request at a time and owns the handshake flags
module pcws_ctrl
    import pcws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output pcws_cmd_t cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_FINISH = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic load;

    // handshake decode
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign load      = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.exec  = accept;
    assign cmd.load  = load;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared by a transfer
    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/pcws_dp.sv
// datapath: queue counters, victim select, slot memory and result register
module pcws_dp
    import pcws_pkg::*;
#(
    parameter int SLOTS_PER_QUEUE = DEF_SLOTS_PER_QUEUE,
    parameter int HANDLE_BITS     = DEF_HANDLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pcws_cmd_t              cmd,
    input  logic                   func,
    input  logic [CPU_BITS-1:0]    cpu,
    input  logic [HANDLE_BITS-1:0] work_in,
    input  logic [CPU_BITS-1:0]    start_offset,
    output logic [STATUS_BITS-1:0] status,
    output logic [HANDLE_BITS-1:0] work_out,
    output logic [CPU_BITS-1:0]    source_cpu,
    output logic                   was_stolen
);

    localparam int SLOT_BITS = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
    localparam int CNT_BITS  = SLOT_BITS + 1;
    localparam int ADDR_BITS = CPU_BITS + SLOT_BITS;
    localparam int MEM_DEPTH = CPU_COUNT * SLOTS_PER_QUEUE;

    logic [CNT_BITS-1:0]    head_reg  [CPU_COUNT];
    logic [CNT_BITS-1:0]    head_next [CPU_COUNT];
    logic [CNT_BITS-1:0]    tail_reg  [CPU_COUNT];
    logic [CNT_BITS-1:0]    tail_next [CPU_COUNT];
    logic [CPU_COUNT-1:0]   busy;
    logic [CPU_COUNT-1:0]   full;

    logic                   found;
    logic [CPU_BITS-1:0]    victim;

    logic [HANDLE_BITS-1:0] slot_mem [MEM_DEPTH];
    logic [HANDLE_BITS-1:0] rdata_reg;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_BITS-1:0]   waddr;
    logic [ADDR_BITS-1:0]   raddr;

    logic [STATUS_BITS-1:0] res_status;
    logic [CPU_BITS-1:0]    res_src;
    logic                   res_stolen;
    logic                   res_read;
    logic [STATUS_BITS-1:0] res_status_reg;
    logic [CPU_BITS-1:0]    res_src_reg;
    logic                   res_stolen_reg;
    logic                   res_read_reg;

    logic [STATUS_BITS-1:0] out_status_reg;
    logic [HANDLE_BITS-1:0] out_work_reg;
    logic [CPU_BITS-1:0]    out_src_reg;
    logic                   out_stolen_reg;

    logic [CNT_BITS-1:0]    own_head;
    logic [CNT_BITS-1:0]    own_head_dec;
    logic [CNT_BITS-1:0]    vic_tail;

    // per-queue empty and full flags
    always_comb
    begin
        for (int q = 0; q < CPU_COUNT; q++)
        begin
            busy[q] = (head_reg[q] != tail_reg[q]);
            full[q] = ((head_reg[q] - tail_reg[q]) == CNT_BITS'(SLOTS_PER_QUEUE));
        end
    end

    // rotated priority scan for the first non-empty other queue
    always_comb
    begin
        logic [CPU_BITS-1:0] cand;
        found  = 1'b0;
        victim = '0;
        cand   = '0;
        for (int i = 0; i < CPU_COUNT; i++)
        begin
            cand = CPU_BITS'(int'(start_offset) + i);
            if (!found && busy[cand] && (cand != cpu))
            begin
                found  = 1'b1;
                victim = cand;
            end
        end
    end

    assign own_head     = head_reg[cpu];
    assign own_head_dec = own_head - CNT_BITS'(1);
    assign vic_tail     = tail_reg[victim];

    // request decision: counter update, slot access and result fields
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        waddr      = {cpu, own_head[SLOT_BITS-1:0]};
        raddr      = {cpu, own_head_dec[SLOT_BITS-1:0]};
        res_status = STAT_DONE;
        res_src    = '0;
        res_stolen = 1'b0;
        res_read   = 1'b0;
        if (func == FUNC_PUSH)
        begin
            if (full[cpu])
            begin
                res_status = STAT_FULL;
            end
            else
            begin
                mem_we         = cmd.exec;
                head_next[cpu] = own_head + CNT_BITS'(1);
            end
        end
        else if (busy[cpu])
        begin
            // pop the newest handle from the own head
            mem_re         = cmd.exec;
            head_next[cpu] = own_head_dec;
            res_src        = cpu;
            res_read       = 1'b1;
        end
        else if (found)
        begin
            // steal the oldest handle from the victim tail
            mem_re            = cmd.exec;
            raddr             = {victim, vic_tail[SLOT_BITS-1:0]};
            tail_next[victim] = vic_tail + CNT_BITS'(1);
            res_src           = victim;
            res_stolen        = 1'b1;
            res_read          = 1'b1;
        end
        else
        begin
            res_status = STAT_NO_WORK;
        end
    end

    // head and tail counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < CPU_COUNT; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[waddr] <= work_in;
        end
        if (mem_re)
        begin
            rdata_reg <= slot_mem[raddr];
        end
    end

    // result fields held until the handle arrives from memory
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= res_status;
            res_src_reg    <= res_src;
            res_stolen_reg <= res_stolen;
            res_read_reg   <= res_read;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_status_reg <= res_status_reg;
            out_work_reg   <= res_read_reg ? rdata_reg : '0;
            out_src_reg    <= res_src_reg;
            out_stolen_reg <= res_stolen_reg;
        end
    end

    assign status     = out_status_reg;
    assign work_out   = out_work_reg;
    assign source_cpu = out_src_reg;
    assign was_stolen = out_stolen_reg;

endmodule

// File: rtl/per_cpu_work_stealing_queues_core.sv
// top level of the per-cpu work stealing queue block
//
// Eight bounded work queues, one per cpu, each a ring of SLOTS_PER_QUEUE handles.
// Requests come in on the s_axis channel: tuser selects push (0) or fetch (1),
// tdata carries cpu, work_in and start_offset. Each request gives exactly one
// result on the m_axis channel: tuser is the status (done, full, no work),
// tdata carries work_out, source_cpu and was_stolen.
// A fetch pops the newest handle of its own queue; if that queue is empty it
// steals the oldest handle of the first non-empty other queue, scanning from
// start_offset upward with wraparound.
// A request transfer updates the counters, reads the slot and registers the result fields;
// the FINISH state then loads the output register, which drives m_axis. The block takes
// no new request until that load is done, and the load waits for a free output register.
// A request is taken while the previous result still waits in the output
// register; if the receiver keeps stalling, the block then holds s_axis_tready
// low until the waiting result is transferred.
// Reset empties every queue at once (head and tail counters cleared); no
// clearing pass is needed, as slots are only read once written.
module per_cpu_work_stealing_queues_core
    import pcws_pkg::*;
#(
    parameter int SLOTS_PER_QUEUE = DEF_SLOTS_PER_QUEUE,
    parameter int HANDLE_BITS     = DEF_HANDLE_BITS,
    localparam int IN_DATA_BITS   = ((HANDLE_BITS + 2 * CPU_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_BITS  = ((HANDLE_BITS + CPU_BITS + 1 + 7) / 8) * 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // cpu, work_in, start_offset, zero pad
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // func
    input  logic                     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // work_out, source_cpu, was_stolen, zero pad
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // status
    output logic [STATUS_BITS-1:0]   m_axis_tuser
);

    pcws_cmd_t              cmd;
    logic [HANDLE_BITS-1:0] work_out;
    logic [CPU_BITS-1:0]    source_cpu;
    logic                   was_stolen;

    // handshake and sequencing
    pcws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // queues and result path
    pcws_dp #(
        .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE),
        .HANDLE_BITS     (HANDLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (s_axis_tuser),
        .cpu          (s_axis_tdata[CPU_BITS-1:0]),
        .work_in      (s_axis_tdata[CPU_BITS +: HANDLE_BITS]),
        .start_offset (s_axis_tdata[CPU_BITS + HANDLE_BITS +: CPU_BITS]),
        .status       (m_axis_tuser),
        .work_out     (work_out),
        .source_cpu   (source_cpu),
        .was_stolen   (was_stolen)
    );

    // result packing
    assign m_axis_tdata = OUT_DATA_BITS'({was_stolen, source_cpu, work_out});

endmodule

// File: rtl/pcws_checker.sv
// port-level checks of the work stealing queue block, bound to the top level
`include "per_cpu_work_stealing_queues_core_defines.svh"

module pcws_checker
    import pcws_pkg::*;
#(
    parameter int HANDLE_BITS    = DEF_HANDLE_BITS,
    localparam int IN_DATA_BITS  = ((HANDLE_BITS + 2 * CPU_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_BITS = ((HANDLE_BITS + CPU_BITS + 1 + 7) / 8) * 8
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    input logic                     s_axis_tuser,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic [STATUS_BITS-1:0]   m_axis_tuser
);

    // a stalled result stays put
    `PCWS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // failed requests carry no handle, source or steal flag
    `PCWS_ASSERT_IMPL(a_fail_zero, m_axis_tvalid && (m_axis_tuser != STAT_DONE), m_axis_tdata == '0, "nonzero data on failed request")

    // one request in work at a time
    `PCWS_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while one is in work")

    // a new result comes only out of a request in work
    `PCWS_ASSERT_IMPL(a_out_origin, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without a request in work")

endmodule

bind per_cpu_work_stealing_queues_core pcws_checker #(
    .HANDLE_BITS (HANDLE_BITS)
) u_pcws_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/work_queue_checker.sv
// stream checker for the per-cpu work stealing queues: predicts every result and compares it
module work_queue_checker
    import pcws_pkg::*;
#(
    parameter int IN_BITS  = 40,
    parameter int OUT_BITS = 40
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_BITS-1:0]     s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_BITS-1:0]    m_tdata,
    input  logic [STATUS_BITS-1:0] m_tuser,
    output int                     failures,
    output int                     outstanding
);

    localparam int SLOTS    = DEF_SLOTS_PER_QUEUE;
    localparam int CNT_BITS = $clog2(2 * SLOTS);
    localparam int IDX_BITS = $clog2(SLOTS);

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [31:0]            work;
        logic [CPU_BITS-1:0]    src;
        logic                   stolen;
    } outcome_t;

    // mirror of the queue set
    logic [31:0]         handle_slots [CPU_COUNT][SLOTS];
    logic [CNT_BITS-1:0] head_cnt [CPU_COUNT] = '{default: '0};
    logic [CNT_BITS-1:0] tail_cnt [CPU_COUNT] = '{default: '0};

    outcome_t awaited_results [$];

    initial failures = 0;
    initial outstanding = 0;

    function automatic logic [CNT_BITS-1:0] fill_level(int q);
        return head_cnt[q] - tail_cnt[q];
    endfunction

    // apply one request to the mirror and return what the block must answer
    function automatic outcome_t serve_request(logic func, logic [CPU_BITS-1:0] cpu,
                                               logic [31:0] work,
                                               logic [CPU_BITS-1:0] offs);
        outcome_t res;
        int victim;
        logic [CNT_BITS-1:0] ptr;
        res = '{status: STAT_DONE, work: '0, src: '0, stolen: 1'b0};
        if (func == FUNC_PUSH) begin
            if (fill_level(cpu) == CNT_BITS'(SLOTS))
                res.status = STAT_FULL;
            else begin
                handle_slots[cpu][head_cnt[cpu][IDX_BITS-1:0]] = work;
                head_cnt[cpu] = head_cnt[cpu] + 1'b1;
            end
            return res;
        end
        // own queue first, newest end
        if (fill_level(cpu) != 0) begin
            ptr = head_cnt[cpu] - 1'b1;
            head_cnt[cpu] = ptr;
            res.work = handle_slots[cpu][ptr[IDX_BITS-1:0]];
            res.src = cpu;
            return res;
        end
        // rotated victim scan, oldest end
        for (int i = 0; i < CPU_COUNT; i++) begin
            victim = (i + offs) % CPU_COUNT;
            if (victim != cpu && fill_level(victim) != 0) begin
                ptr = tail_cnt[victim];
                tail_cnt[victim] = ptr + 1'b1;
                res.work = handle_slots[victim][ptr[IDX_BITS-1:0]];
                res.src = CPU_BITS'(victim);
                res.stolen = 1'b1;
                return res;
            end
        end
        res.status = STAT_NO_WORK;
        return res;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        failures++;
    endtask

    // result transfer first, then request transfer of the same edge
    always @(posedge clk) begin
        outcome_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0)
                    flag_mismatch("unexpected result", {30'b0, m_tuser}, '0);
                else begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.status)
                        flag_mismatch("status", {30'b0, m_tuser}, {30'b0, want.status});
                    if (m_tdata[31:0] !== want.work)
                        flag_mismatch("work_out", m_tdata[31:0], want.work);
                    if (m_tdata[34:32] !== want.src)
                        flag_mismatch("source_cpu", {29'b0, m_tdata[34:32]}, {29'b0, want.src});
                    if (m_tdata[35] !== want.stolen)
                        flag_mismatch("was_stolen", {31'b0, m_tdata[35]}, {31'b0, want.stolen});
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(serve_request(s_tuser, s_tdata[2:0], s_tdata[34:3],
                                                        s_tdata[37:35]));
            outstanding <= awaited_results.size();
        end
    end

endmodule

// File: tb/per_cpu_work_stealing_queues_core_tb.sv
// testbench top for the per-cpu work stealing queues: stimulus, flow control and verdict
module per_cpu_work_stealing_queues_core_tb;
    import pcws_pkg::*;

    localparam int IN_BITS   = 40;
    localparam int OUT_BITS  = 40;
    localparam int CYCLE_CAP = 400000;
    localparam int SEGMENTS  = 16;
    localparam int SEG_ITEMS = 100;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_BITS-1:0]     s_data = '0;
    logic                   s_user = FUNC_PUSH;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_BITS-1:0]    m_data;
    logic [STATUS_BITS-1:0] m_user;

    int failures;
    int outstanding;
    int cycles = 0;
    int burst_left = 0;
    int ready_left = 0;
    int ready_mode = 0;

    per_cpu_work_stealing_queues_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    work_queue_checker #(.IN_BITS(IN_BITS), .OUT_BITS(OUT_BITS)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_valid),
        .s_tready    (s_ready),
        .s_tdata     (s_data),
        .s_tuser     (s_user),
        .m_tvalid    (m_valid),
        .m_tready    (m_ready),
        .m_tdata     (m_data),
        .m_tuser     (m_user),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stalls: always ready, coin flip, or mostly stalled, in stretches
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            ready_left <= $urandom_range(10, 150);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // one request transfer, with bursts and gaps on the sender side
    task automatic send_request(logic func, logic [2:0] cpu, logic [31:0] work,
                                logic [2:0] offs);
        int gap;
        s_valid <= 1'b1;
        s_user <= func;
        s_data <= {2'b00, offs, work, cpu};
        do @(posedge clk); while (!s_ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic push_work(logic [2:0] cpu, logic [31:0] work);
        send_request(FUNC_PUSH, cpu, work, 3'($urandom_range(0, 7)));
    endtask

    task automatic fetch_work(logic [2:0] cpu, logic [2:0] offs);
        send_request(FUNC_FETCH, cpu, $urandom, offs);
    endtask

    initial
    begin
        int mode;
        int hot;
        int push_pct;
        logic [2:0] cpu;
        logic [31:0] work;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no work anywhere
        fetch_work(3'd0, 3'd0);
        fetch_work(3'd7, 3'd7);
        // zero and all-ones handles, own pops newest first
        push_work(3'd0, 32'h0);
        push_work(3'd0, 32'hffff_ffff);
        fetch_work(3'd0, 3'd0);
        fetch_work(3'd0, 3'd0);
        // steal takes the oldest from the first non-empty victim
        push_work(3'd3, 32'h1111_0001);
        push_work(3'd3, 32'h1111_0002);
        push_work(3'd5, 32'h5555_0001);
        fetch_work(3'd0, 3'd0);
        fetch_work(3'd5, 3'd5);
        // scan wraps around from a high start
        fetch_work(3'd1, 3'd4);
        push_work(3'd7, $urandom);
        push_work(3'd1, $urandom);
        fetch_work(3'd2, 3'd7);
        fetch_work(3'd1, 3'd1);
        // start offset on the requester itself is skipped
        push_work(3'd3, $urandom);
        fetch_work(3'd2, 3'd2);
        push_work(3'd0, $urandom);
        fetch_work(3'd7, 3'd7);
        fetch_work(3'd7, 3'd0);

        // random segments: balanced, fill one queue, drain, push heavy
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            mode = $urandom_range(0, 3);
            hot = $urandom_range(0, 7);
            case (mode)
                0: push_pct = 50;
                1: push_pct = 92;
                2: push_pct = 15;
                default: push_pct = 70;
            endcase
            for (int k = 0; k < SEG_ITEMS; k++)
            begin
                if (mode == 1 && $urandom_range(0, 9) < 8)
                    cpu = 3'(hot);
                else
                    cpu = 3'($urandom_range(0, 7));
                work = ($urandom_range(0, 31) == 0) ? 32'h0 : 32'($urandom);
                if ($urandom_range(0, 99) < push_pct)
                    push_work(cpu, work);
                else
                    fetch_work(cpu, 3'($urandom_range(0, 7)));
            end
        end

        // drain
        s_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
